FILE: hw/rtl/imu_dfr_pkg.sv
// package for the imu frame deframer: frame geometry, register codes and types
// no dependencies; imported by every module of the block
package imu_dfr_pkg;

    localparam int FRAME_BYTES   = 11;
    localparam int PAYLOAD_BYTES = 8;

    // bytes held in the cell row; the last frame byte is the incoming word
    localparam int HOLD_BYTES = FRAME_BYTES - 1;
    localparam int FILL_W     = $clog2(HOLD_BYTES + 1);

    localparam int BYTE_W    = 8;
    localparam int PAYLOAD_W = 64;
    localparam int CFG_IDX_W = 2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [FILL_W-1:0] fill_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER  = 2'd0,
        CFG_ID_LOW  = 2'd1,
        CFG_ID_HIGH = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        byte_t header_byte;
        byte_t id_low;
        byte_t id_high;
    } cfg_t;

    localparam byte_t HEADER_RST  = 8'd85;
    localparam byte_t ID_LOW_RST  = 8'd80;
    localparam byte_t ID_HIGH_RST = 8'd90;

endpackage

FILE: hw/rtl/imu_frame_deframer_unit.sv
// imu frame deframer top level: cell row, running checksum, output register
// depends on imu_dfr_pkg, imu_dfr_cell and imu_dfr_match
//
// result: a frame's result is registered and valid in the cycle after its last word is accepted
// throughput: one word per cycle; the output register lets a new word in while
//   a result waits, so in_ready only drops when a result is held and out_ready is low
// reset: window and running sum cleared, fill count zero, registers at defaults
module imu_frame_deframer_unit
    import imu_dfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  byte_t                cfg_data,
    // received byte channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  byte_t                rx_byte,
    // frame result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output byte_t                frame_id,
    output logic [PAYLOAD_W-1:0] payload
);

    // configuration registers
    cfg_t cfg_reg;
    cfg_t cfg_next;

    // window control: fill count of held bytes and their running sum mod 256
    fill_t fill_reg;
    fill_t fill_next;
    byte_t sum_reg;
    byte_t sum_next;

    // output register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    byte_t                frame_id_reg;
    byte_t                frame_id_next;
    logic [PAYLOAD_W-1:0] payload_reg;
    logic [PAYLOAD_W-1:0] payload_next;

    logic                 in_fire;
    logic                 cfg_fire;
    logic                 match;
    logic                 frame_hit;
    logic [PAYLOAD_W-1:0] payload_word;

    // cell row: cell 0 is the oldest byte, the newest word enters at the top
    byte_t cell_q [HOLD_BYTES];

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    genvar gi;
    generate
        for (gi = 0; gi < HOLD_BYTES; gi++)
        begin : g_cell
            if (gi == HOLD_BYTES - 1)
            begin : g_top
                imu_dfr_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (in_fire),
                    .d        (rx_byte),
                    .q        (cell_q[gi])
                );
            end
            else
            begin : g_mid
                imu_dfr_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (in_fire),
                    .d        (cell_q[gi+1]),
                    .q        (cell_q[gi])
                );
            end
        end
    endgenerate

    // the incoming word is the checksum byte; held bytes are frame bytes 0 and up
    imu_dfr_match u_match (
        .cfg        (cfg_reg),
        .head_byte  (cell_q[0]),
        .id_byte    (cell_q[1]),
        .sum        (sum_reg),
        .check_byte (rx_byte),
        .match      (match)
    );

    assign frame_hit = in_fire && (fill_reg == fill_t'(HOLD_BYTES)) && match;

    // payload lanes: frame byte 2+k, zero where that would reach the checksum byte
    generate
        for (gi = 0; gi < PAYLOAD_W / BYTE_W; gi++)
        begin : g_lane
            if ((gi < PAYLOAD_BYTES) && (gi + 2 < HOLD_BYTES))
            begin : g_used
                assign payload_word[gi*BYTE_W +: BYTE_W] = cell_q[gi+2];
            end
            else
            begin : g_zero
                assign payload_word[gi*BYTE_W +: BYTE_W] = '0;
            end
        end
    endgenerate

    // config write decode, out-of-range index ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_fire)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_HEADER:  cfg_next.header_byte = cfg_data;
                CFG_ID_LOW:  cfg_next.id_low      = cfg_data;
                CFG_ID_HIGH: cfg_next.id_high     = cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    // window bookkeeping: the row shifts on every accepted word, the sum tracks the shift,
    // a good frame empties the window and a bad one just slides by a byte
    always_comb
    begin
        fill_next = fill_reg;
        sum_next  = sum_reg;
        if (in_fire)
        begin
            sum_next = sum_reg - cell_q[0] + rx_byte;
            if (frame_hit)
            begin
                fill_next = '0;
            end
            else if (fill_reg != fill_t'(HOLD_BYTES))
            begin
                fill_next = fill_reg + fill_t'(1);
            end
        end
    end

    // output register: load on a good frame, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        frame_id_next  = frame_id_reg;
        payload_next   = payload_reg;
        if (frame_hit)
        begin
            out_valid_next = 1'b1;
            frame_id_next  = cell_q[1];
            payload_next   = payload_word;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_byte <= HEADER_RST;
            cfg_reg.id_low      <= ID_LOW_RST;
            cfg_reg.id_high     <= ID_HIGH_RST;
            fill_reg            <= '0;
            sum_reg             <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        frame_id_reg <= frame_id_next;
        payload_reg  <= payload_next;
    end

    assign out_valid = out_valid_reg;
    assign frame_id  = frame_id_reg;
    assign payload   = payload_reg;

    // fill count never runs past the held depth
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= fill_t'(HOLD_BYTES))
        else $error("fill count beyond window depth");

    // a result only comes from a full window, which is then emptied
    a_hit_full: assert property (@(posedge clk) disable iff (!rst_n)
        frame_hit |-> fill_reg == fill_t'(HOLD_BYTES))
        else $error("frame accepted from partial window");

    a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        frame_hit |=> (fill_reg == '0) && out_valid_reg)
        else $error("accepted frame did not clear window or load result");

    // words are only held back while a result is pending
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid_reg)
        else $error("input stalled with no pending result");

endmodule

FILE: hw/rtl/imu_dfr_cell.sv
// one cell of the byte shift row: holds a byte, takes its neighbour's on shift
// depends on imu_dfr_pkg
module imu_dfr_cell
    import imu_dfr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  shift_en,
    input  byte_t d,
    output byte_t q
);

    byte_t data_reg;
    byte_t data_next;

    always_comb
    begin
        data_next = shift_en ? d : data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign q = data_reg;

endmodule

FILE: hw/rtl/imu_dfr_match.sv
// frame check: header, id range and checksum against the incoming word
// depends on imu_dfr_pkg
module imu_dfr_match
    import imu_dfr_pkg::*;
(
    input  cfg_t  cfg,
    input  byte_t head_byte,
    input  byte_t id_byte,
    input  byte_t sum,
    input  byte_t check_byte,
    output logic  match
);

    logic head_ok;
    logic id_ok;
    logic sum_ok;

    always_comb
    begin
        head_ok = (head_byte == cfg.header_byte);
        id_ok   = (id_byte >= cfg.id_low) && (id_byte <= cfg.id_high);
        sum_ok  = (sum == check_byte);
        match   = head_ok && id_ok && sum_ok;
    end

endmodule
